// ===== design/playfair_pkg.sv =====
// ============================================================================
// Playfair digraph encipher package
// Shared letter codes, key square types and cell lookup helpers.
// ============================================================================
package playfair_pkg;

    localparam int CODE_W  = 5;
    localparam int SIDE    = 5;
    localparam int IDX_W   = 3;
    localparam int ROW_W   = CODE_W * SIDE;

    typedef logic [CODE_W-1:0] letter_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef row_t              square_t [SIDE];

    localparam letter_t LETTER_I = 5'd8;
    localparam letter_t LETTER_J = 5'd9;
    localparam letter_t LETTER_X = 5'd23;

    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    final_mark;
    } pair_t;

    typedef struct packed {
        letter_t cipher_first;
        letter_t cipher_second;
        logic    final_pair;
    } result_t;

    typedef struct packed {
        idx_t row;
        idx_t col;
    } pos_t;

    function automatic idx_t next_idx(input idx_t i);
        next_idx = (i == idx_t'(SIDE - 1)) ? idx_t'(0) : idx_t'(i + idx_t'(1));
    endfunction

endpackage

// ===== design/playfair_digraph_encrypt.sv =====
// ============================================================================
// Playfair digraph encrypt
// Streams plaintext letters in and enciphered digraphs out.
// ============================================================================
// Letters enter on the s_axis channel, one word each, with tlast marking the
// final letter of a message. Digraphs leave on the m_axis channel, one word
// each, with tlast marking the last digraph of the message. A letter that
// equals the pending one yields a pair with filler x; an odd last letter is
// also padded with x, so one letter yields zero, one or two digraphs.
// The key square is loaded through the APB port, one row per register.
// Accepted letters have their pairs registered and then enciphered into a
// four-word output queue that feeds m_axis. While s_axis_tready is high,
// one letter can be accepted every cycle; a letter with two digraphs puts
// two words in the queue. Two pair registers feed two encipher units that
// push into it, and s_axis_tready drops only when it cannot take the worst
// case in flight. A stalled receiver fills the queue and then holds the input
// off. Reset clears the key square, the pending letter and the queue.
// ============================================================================
module playfair_digraph_encrypt
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] plain_letter
    input  logic        s_axis_tlast,   // message_end

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] cipher_first, [9:5] cipher_second
    output logic        m_axis_tlast,   // final_pair

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QDEPTH = 4;

    playfair_pkg::square_t square_reg;
    logic [2:0]            reg_index;

    playfair_pkg::letter_t held_letter_reg;
    playfair_pkg::letter_t held_letter_next;
    logic                  held_valid_reg;
    logic                  held_valid_next;

    playfair_pkg::letter_t letter;
    logic                  accept;
    playfair_pkg::pair_t   gen_pair0;
    playfair_pkg::pair_t   gen_pair1;
    logic [1:0]            gen_count;

    playfair_pkg::pair_t   stage_pair0_reg;
    playfair_pkg::pair_t   stage_pair1_reg;
    logic [1:0]            stage_count_reg;
    logic [1:0]            stage_count_next;

    playfair_pkg::result_t result0;
    playfair_pkg::result_t result1;

    playfair_pkg::result_t queue_mem [QDEPTH];
    logic [1:0]            wr_ptr_reg;
    logic [1:0]            rd_ptr_reg;
    logic [2:0]            queue_count_reg;
    logic [2:0]            queue_count_next;
    logic                  pop;
    playfair_pkg::result_t head;

    // Configuration port
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];

    always_comb
    begin
        prdata = '0;
        if (reg_index < 3'(playfair_pkg::SIDE))
        begin
            prdata = 32'(square_reg[reg_index]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < playfair_pkg::SIDE; k++)
            begin
                square_reg[k] <= '0;
            end
        end
        else if (psel && penable && pwrite && pready && (reg_index < 3'(playfair_pkg::SIDE)))
        begin
            square_reg[reg_index] <= pwdata[playfair_pkg::ROW_W-1:0];
        end
    end

    // Pair formation
    assign accept = s_axis_tvalid && s_axis_tready;
    assign letter = (s_axis_tdata[4:0] == playfair_pkg::LETTER_J) ?
                    playfair_pkg::LETTER_I : s_axis_tdata[4:0];

    always_comb
    begin
        gen_pair0        = '{held_letter_reg, playfair_pkg::LETTER_X, 1'b0};
        gen_pair1        = '{letter, playfair_pkg::LETTER_X, 1'b1};
        gen_count        = 2'd0;
        held_letter_next = letter;
        held_valid_next  = 1'b1;
        if (held_valid_reg && (held_letter_reg == letter))
        begin
            if (s_axis_tlast)
            begin
                gen_count        = 2'd2;
                held_letter_next = '0;
                held_valid_next  = 1'b0;
            end
            else
            begin
                gen_count = 2'd1;
            end
        end
        else if (held_valid_reg)
        begin
            gen_pair0        = '{held_letter_reg, letter, s_axis_tlast};
            gen_count        = 2'd1;
            held_letter_next = '0;
            held_valid_next  = 1'b0;
        end
        else if (s_axis_tlast)
        begin
            gen_pair0        = '{letter, playfair_pkg::LETTER_X, 1'b1};
            gen_count        = 2'd1;
            held_letter_next = '0;
            held_valid_next  = 1'b0;
        end
    end

    assign stage_count_next = accept ? gen_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            stage_count_reg <= 2'd0;
        end
        else
        begin
            stage_count_reg <= stage_count_next;
            if (accept)
            begin
                held_letter_reg <= held_letter_next;
                held_valid_reg  <= held_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_pair0_reg <= gen_pair0;
            stage_pair1_reg <= gen_pair1;
        end
    end

    // Encipher both staged pairs
    playfair_encipher u_encipher0
    (
        .square (square_reg),
        .pair   (stage_pair0_reg),
        .result (result0)
    );

    playfair_encipher u_encipher1
    (
        .square (square_reg),
        .pair   (stage_pair1_reg),
        .result (result1)
    );

    // Output queue
    assign pop              = m_axis_tvalid && m_axis_tready;
    assign queue_count_next = queue_count_reg + 3'(stage_count_reg) - 3'(pop);
    assign s_axis_tready    = (4'(queue_count_reg) + 4'(stage_count_reg)) <= 4'(QDEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (stage_count_reg != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= result0;
        end
        if (stage_count_reg == 2'd2)
        begin
            queue_mem[wr_ptr_reg + 2'd1] <= result1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            queue_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg      <= wr_ptr_reg + stage_count_reg;
            rd_ptr_reg      <= rd_ptr_reg + 2'(pop);
            queue_count_reg <= queue_count_next;
        end
    end

    assign head          = queue_mem[rd_ptr_reg];
    assign m_axis_tvalid = (queue_count_reg != 3'd0);
    assign m_axis_tdata  = {6'b0, head.cipher_second, head.cipher_first};
    assign m_axis_tlast  = head.final_pair;

endmodule

// ===== design/playfair_encipher.sv =====
// ============================================================================
// Playfair pair encipher
// Locates both letters of a pair in the key square and applies the
// same-row, same-column or rectangle rule.
// ============================================================================
module playfair_encipher
(
    input  playfair_pkg::square_t square,
    input  playfair_pkg::pair_t   pair,
    output playfair_pkg::result_t result
);

    playfair_pkg::letter_t cells [playfair_pkg::SIDE][playfair_pkg::SIDE];
    playfair_pkg::pos_t    pos_a;
    playfair_pkg::pos_t    pos_b;

    always_comb
    begin
        for (int r = 0; r < playfair_pkg::SIDE; r++)
        begin
            for (int c = 0; c < playfair_pkg::SIDE; c++)
            begin
                cells[r][c] = square[r][c*playfair_pkg::CODE_W +: playfair_pkg::CODE_W];
            end
        end
    end

    // The last match in row-major order wins; an absent letter sits at row 0, column 0.
    always_comb
    begin
        pos_a = '0;
        pos_b = '0;
        for (int r = 0; r < playfair_pkg::SIDE; r++)
        begin
            for (int c = 0; c < playfair_pkg::SIDE; c++)
            begin
                if (cells[r][c] == pair.first)
                begin
                    pos_a.row = playfair_pkg::idx_t'(r);
                    pos_a.col = playfair_pkg::idx_t'(c);
                end
                if (cells[r][c] == pair.second)
                begin
                    pos_b.row = playfair_pkg::idx_t'(r);
                    pos_b.col = playfair_pkg::idx_t'(c);
                end
            end
        end
    end

    always_comb
    begin
        result.final_pair = pair.final_mark;
        if (pos_a.row == pos_b.row)
        begin
            result.cipher_first  = cells[pos_a.row][playfair_pkg::next_idx(pos_a.col)];
            result.cipher_second = cells[pos_b.row][playfair_pkg::next_idx(pos_b.col)];
        end
        else if (pos_a.col == pos_b.col)
        begin
            result.cipher_first  = cells[playfair_pkg::next_idx(pos_a.row)][pos_a.col];
            result.cipher_second = cells[playfair_pkg::next_idx(pos_b.row)][pos_b.col];
        end
        else
        begin
            result.cipher_first  = cells[pos_a.row][pos_b.col];
            result.cipher_second = cells[pos_b.row][pos_a.col];
        end
    end

endmodule

// ===== design/playfair_digraph_encrypt_checker.sv =====
// ============================================================================
// Playfair digraph encrypt checker
// Port-level checks on the output stream and the configuration port.
// ============================================================================
module playfair_digraph_encrypt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // A stalled output word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // The last letter of a message always produces a digraph, so the output goes valid after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> ##1 m_axis_tvalid)
        else $error("no digraph after the final letter");

    // Reset empties the output queue.
    assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // Row 0 written and then read back at the same address returns the data.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[4:2] == $past(paddr[4:2]) || 1'b1) ##1
        (psel && !pwrite && (paddr == $past(paddr)) && (paddr[4:2] == 3'd0))
        |-> prdata[24:0] == $past(pwdata[24:0]))
        else $error("key square row read back wrong");

endmodule

bind playfair_digraph_encrypt playfair_digraph_encrypt_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

// ===== dv/tb_playfair_digraph_encrypt.sv =====
// ============================================================================
// Playfair digraph encrypt testbench
// Streams letters into the block under several key squares and idle
// patterns, predicts every enciphered digraph and checks the output stream.
// ============================================================================
module tb_playfair_digraph_encrypt;

    localparam int ROW_STRIDE   = 4;
    localparam int PHASES       = 6;
    localparam int WORDS_PER_PH = 216;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    localparam playfair_pkg::letter_t L_A = 5'd0;
    localparam playfair_pkg::letter_t L_B = 5'd1;
    localparam playfair_pkg::letter_t L_E = 5'd4;
    localparam playfair_pkg::letter_t L_F = 5'd5;
    localparam playfair_pkg::letter_t L_G = 5'd6;
    localparam playfair_pkg::letter_t L_V = 5'd21;
    localparam playfair_pkg::letter_t L_Z = 5'd25;

    typedef enum int { KEY_ALPHA, KEY_SHUFFLED, KEY_NOISE, KEY_ONES, KEY_ZERO } key_kind_t;

    typedef struct packed {
        logic                  rekey;
        playfair_pkg::letter_t letter;
        logic                  last;
        logic                  typed;
        logic [1:0]            n;
        playfair_pkg::result_t r0;
        playfair_pkg::result_t r1;
    } stim_row_t;

    localparam playfair_pkg::result_t ZD = playfair_pkg::result_t'{5'd0, 5'd0, 1'b0};
    localparam playfair_pkg::result_t ZF = playfair_pkg::result_t'{5'd0, 5'd0, 1'b1};

    // The first rows run on the all-zero square left by reset, where every
    // digraph enciphers to a pair of zero codes.
    localparam stim_row_t DIRECTED [25] = '{
        '{1'b0, L_A,                    1'b0, 1'b1, 2'd0, ZD, ZD},
        '{1'b0, L_A,                    1'b0, 1'b1, 2'd1, ZD, ZD},
        '{1'b0, L_Z,                    1'b1, 1'b1, 2'd1, ZF, ZD},
        '{1'b0, playfair_pkg::LETTER_J, 1'b1, 1'b1, 2'd1, ZF, ZD},
        '{1'b0, 5'd31,                  1'b0, 1'b1, 2'd0, ZD, ZD},
        '{1'b0, 5'd31,                  1'b1, 1'b1, 2'd2, ZD, ZF},
        '{1'b1, L_A,                    1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_B,                    1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_A,                    1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_F,                    1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_A,                    1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_G,                    1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, playfair_pkg::LETTER_X, 1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, playfair_pkg::LETTER_X, 1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, playfair_pkg::LETTER_X, 1'b1, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, playfair_pkg::LETTER_J, 1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, playfair_pkg::LETTER_I, 1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_E,                    1'b1, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, 5'd26,                  1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, 5'd30,                  1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_Z,                    1'b1, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_E,                    1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_Z,                    1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_Z,                    1'b0, 1'b0, 2'd0, ZD, ZD},
        '{1'b0, L_V,                    1'b1, 1'b0, 2'd0, ZD, ZD}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [4:0] plain_letter
    logic        s_axis_tlast = 1'b0;   // message_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [4:0] cipher_first, [9:5] cipher_second
    logic        m_axis_tlast;          // final_pair
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    playfair_pkg::row_t    key_rows [playfair_pkg::SIDE];
    playfair_pkg::letter_t pend_letter;
    logic                  pend_valid;
    playfair_pkg::result_t cipher_q [$];
    int                    fail_count = 0;
    int                    send_idle = 0;
    int                    recv_idle = 0;
    int                    hold_requests = 0;

    playfair_digraph_encrypt u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    function automatic playfair_pkg::letter_t key_cell(input int r, input int c);
        return key_rows[r % playfair_pkg::SIDE]
                       [playfair_pkg::CODE_W * (c % playfair_pkg::SIDE) +: playfair_pkg::CODE_W];
    endfunction

    function automatic playfair_pkg::pos_t find_letter(input playfair_pkg::letter_t l);
        playfair_pkg::pos_t p;
        p = '0;
        for (int r = 0; r < playfair_pkg::SIDE; r++)
            for (int c = 0; c < playfair_pkg::SIDE; c++)
                if (key_cell(r, c) == l)
                begin
                    p.row = playfair_pkg::idx_t'(r);
                    p.col = playfair_pkg::idx_t'(c);
                end
        return p;
    endfunction

    function automatic playfair_pkg::result_t encipher_digraph(
        input playfair_pkg::letter_t a, input playfair_pkg::letter_t b, input logic fin);
        playfair_pkg::pos_t    pa;
        playfair_pkg::pos_t    pb;
        playfair_pkg::result_t d;
        pa = find_letter(a);
        pb = find_letter(b);
        if (pa.row == pb.row)
        begin
            d.cipher_first  = key_cell(int'(pa.row), int'(pa.col) + 1);
            d.cipher_second = key_cell(int'(pb.row), int'(pb.col) + 1);
        end
        else if (pa.col == pb.col)
        begin
            d.cipher_first  = key_cell(int'(pa.row) + 1, int'(pa.col));
            d.cipher_second = key_cell(int'(pb.row) + 1, int'(pb.col));
        end
        else
        begin
            d.cipher_first  = key_cell(int'(pa.row), int'(pb.col));
            d.cipher_second = key_cell(int'(pb.row), int'(pa.col));
        end
        d.final_pair = fin;
        return d;
    endfunction

    task automatic form_digraphs(input playfair_pkg::letter_t raw, input logic fin,
                                 output playfair_pkg::result_t d0,
                                 output playfair_pkg::result_t d1, output int n);
        playfair_pkg::letter_t l;
        playfair_pkg::result_t d;
        l  = (raw == playfair_pkg::LETTER_J) ? playfair_pkg::LETTER_I : raw;
        n  = 0;
        d0 = '0;
        d1 = '0;
        if (pend_valid)
        begin
            if (pend_letter == l)
            begin
                d0 = encipher_digraph(pend_letter, playfair_pkg::LETTER_X, 1'b0);
                n = 1;
                pend_valid = 1'b0;
            end
            else
            begin
                d0 = encipher_digraph(pend_letter, l, fin);
                n = 1;
                pend_valid = 1'b0;
                pend_letter = '0;
                return;
            end
        end
        if (fin)
        begin
            d = encipher_digraph(l, playfair_pkg::LETTER_X, 1'b1);
            if (n == 0)
                d0 = d;
            else
                d1 = d;
            n++;
            pend_valid = 1'b0;
            pend_letter = '0;
        end
        else
        begin
            pend_letter = l;
            pend_valid = 1'b1;
        end
    endtask

    task automatic send_letter(input playfair_pkg::letter_t l, input logic fin,
                               input logic typed, input int tn,
                               input playfair_pkg::result_t t0,
                               input playfair_pkg::result_t t1);
        playfair_pkg::result_t d0;
        playfair_pkg::result_t d1;
        int                    n;
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, l};
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        form_digraphs(l, fin, d0, d1, n);
        if (typed)
            n = tn;
        else
        begin
            t0 = d0;
            t1 = d1;
        end
        if (n > 0)
            cipher_q.push_back(t0);
        if (n > 1)
            cipher_q.push_back(t1);
        @(negedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input int idx, input playfair_pkg::row_t v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(ROW_STRIDE * idx);
        pwdata  <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        key_rows[idx] = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_key(input key_kind_t kind);
        playfair_pkg::letter_t codes [25];
        playfair_pkg::row_t    rows [playfair_pkg::SIDE];
        int                    k;
        int                    m;
        playfair_pkg::letter_t t;
        k = 0;
        for (int code = 0; code < 26; code++)
            if (playfair_pkg::letter_t'(code) != playfair_pkg::LETTER_J)
            begin
                codes[k] = playfair_pkg::letter_t'(code);
                k++;
            end
        if (kind == KEY_SHUFFLED)
        begin
            for (int i = 24; i > 0; i--)
            begin
                m = $urandom_range(i);
                t = codes[i];
                codes[i] = codes[m];
                codes[m] = t;
            end
            if ($urandom_range(1) == 1)
                codes[$urandom_range(24)] = playfair_pkg::letter_t'($urandom_range(31));
        end
        for (int r = 0; r < playfair_pkg::SIDE; r++)
        begin
            for (int c = 0; c < playfair_pkg::SIDE; c++)
                rows[r][playfair_pkg::CODE_W * c +: playfair_pkg::CODE_W] =
                    codes[playfair_pkg::SIDE * r + c];
            case (kind)
                KEY_NOISE: rows[r] = playfair_pkg::row_t'($urandom);
                KEY_ONES:  rows[r] = '1;
                KEY_ZERO:  rows[r] = '0;
                default:   ;
            endcase
            apb_write(r, rows[r]);
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin : check_out
        playfair_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cipher_q.size() == 0)
            begin
                $error("unexpected word %h", m_axis_tdata[9:0]);
                fail_count++;
            end
            else
            begin
                want = cipher_q.pop_front();
                if (m_axis_tdata[4:0] !== want.cipher_first)
                begin
                    $error("cipher_first expected %0d got %0d",
                           want.cipher_first, m_axis_tdata[4:0]);
                    fail_count++;
                end
                if (m_axis_tdata[9:5] !== want.cipher_second)
                begin
                    $error("cipher_second expected %0d got %0d",
                           want.cipher_second, m_axis_tdata[9:5]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.final_pair)
                begin
                    $error("final_pair expected %0d got %0d", want.final_pair, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        key_kind_t             plan [PHASES];
        playfair_pkg::letter_t l;
        playfair_pkg::letter_t prev;
        logic                  fin;
        int                    sel;
        plan = '{KEY_SHUFFLED, KEY_ONES, KEY_SHUFFLED, KEY_NOISE, KEY_SHUFFLED, KEY_ZERO};
        for (int r = 0; r < playfair_pkg::SIDE; r++)
            key_rows[r] = '0;
        pend_letter = '0;
        pend_valid  = 1'b0;
        prev = L_A;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 25; i++)
        begin
            if (DIRECTED[i].rekey)
            begin
                drain();
                load_key(KEY_ALPHA);
            end
            send_letter(DIRECTED[i].letter, DIRECTED[i].last, DIRECTED[i].typed,
                        int'(DIRECTED[i].n), DIRECTED[i].r0, DIRECTED[i].r1);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            load_key(plan[p]);
            case (p / 2)
                0:
                begin
                    send_idle = 25;
                    recv_idle = 83;
                end
                1:
                begin
                    send_idle = 83;
                    recv_idle = 25;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (p == 0 || p == 4)
                hold_requests++;
            for (int k = 0; k < WORDS_PER_PH; k++)
            begin
                sel = $urandom_range(15);
                if (sel < 3)
                    l = prev;
                else if (sel < 5)
                    l = playfair_pkg::LETTER_X;
                else if (sel == 5)
                    l = playfair_pkg::letter_t'($urandom_range(31));
                else
                    l = playfair_pkg::letter_t'($urandom_range(25));
                fin = (k == WORDS_PER_PH - 1) || ($urandom_range(7) == 0);
                send_letter(l, fin, 1'b0, 0, ZD, ZD);
                prev = l;
            end
        end

        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/playfair_pkg.sv
design/playfair_encipher.sv
design/playfair_digraph_encrypt.sv
design/playfair_digraph_encrypt_checker.sv
dv/tb_playfair_digraph_encrypt.sv
